@@ src/qrrs_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, result codes and sideband types for the quadratic root solver.
// No dependencies; every other file refers to it by scoped names.
package qrrs_pkg;

  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 16;
  localparam int ROOT_W    = 34;
  localparam int KIND_W    = 3;

  // b*b and a*c magnitudes, then the discriminant with one bit of growth
  localparam int PROD_W = 2 * COEF_W;
  localparam int DISC_W = PROD_W + 1;
  // discriminant padded to whole bit pairs for the digit-by-digit root
  localparam int QPAD_W = 2 * ((DISC_W + 1) / 2);
  localparam int SQRT_W = QPAD_W / 2 + FRAC_BITS;
  localparam int SQ_REM_W = SQRT_W + 2;

  // -b or -c scaled by 2^FRAC_BITS, signed
  localparam int NB_W  = COEF_W + FRAC_BITS + 1;
  // numerator magnitude (nb +/- s) and denominator magnitude (2a or b)
  localparam int NUM_W = SQRT_W + 1;
  localparam int DEN_W = COEF_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TWO    = 3'd0,
    KIND_REPEAT = 3'd1,
    KIND_LINEAR = 3'd2,
    KIND_NONE   = 3'd3,
    KIND_ALL    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [NB_W-1:0]  nb;
    logic signed [DEN_W-1:0] den;
  } sq_side_t;

  typedef struct packed {
    kind_t kind;
    logic  neg;
  } div_side_t;

endpackage

@@ src/qrrs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for coefficient and result transactions.
// Depends on qrrs_pkg for field widths.
interface qrrs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qrrs_pkg::COEF_W-1:0]   coef_a;
  logic signed [qrrs_pkg::COEF_W-1:0]   coef_b;
  logic signed [qrrs_pkg::COEF_W-1:0]   coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrrs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [qrrs_pkg::KIND_W-1:0]          root_kind;
  logic signed [qrrs_pkg::ROOT_W-1:0]   root_plus;
  logic signed [qrrs_pkg::ROOT_W-1:0]   root_minus;

  modport source (output valid, root_kind, root_plus, root_minus, input ready);
  modport sink   (input valid, root_kind, root_plus, root_minus, output ready);
endinterface

@@ src/quadratic_real_root_solver.sv @@
`timescale 1ns / 1ps
// Real roots of a*x*x + b*x + c = 0 in signed Q17.16, fully pipelined.
// Stages: 2 discriminant stages, 33 square-root stages, 1 numerator stage,
// 34 divider stages and the output register. Throughput one transaction per cycle while the output is not held.
// The whole pipeline holds while a result waits at the output; synchronous active-low
// reset clears all valid bits. Depends on qrrs_pkg, qrrs_if, qrrs_disc, qrrs_sqrt, qrrs_div.
module quadratic_real_root_solver (
  input  logic        clk,
  input  logic        rst_n,
  qrrs_in_if.sink     in_ch,
  qrrs_out_if.source  out_ch
);

  localparam int NW = qrrs_pkg::NUM_W;
  localparam int RW = qrrs_pkg::ROOT_W;
  localparam int SW = qrrs_pkg::NB_W + 2;

  logic en;
  logic out_valid_r;

  logic                          dc_valid;
  logic [qrrs_pkg::DISC_W-1:0]   dc_q;
  qrrs_pkg::sq_side_t            dc_side;
  logic                          sq_valid;
  logic [qrrs_pkg::SQRT_W-1:0]   sq_root;
  qrrs_pkg::sq_side_t            sq_side;

  logic signed [SW-1:0]          s_ext, num_p, num_m;
  logic                          den_neg;
  logic                          n_valid_r;
  logic [NW-1:0]                 nump_r, numm_r;
  logic [qrrs_pkg::DEN_W-1:0]    den_r;
  qrrs_pkg::div_side_t           sidep_r, sidem_r;

  logic                          dp_valid, dm_valid;
  logic [NW-1:0]                 quo_p, quo_m;
  qrrs_pkg::div_side_t           dp_side, dm_side;

  logic [RW-1:0]                 rp_nxt, rm_nxt;
  qrrs_pkg::kind_t               kind_r;
  logic [RW-1:0]                 rp_r, rm_r;

  // advance every stage unless a result is held at the output
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  qrrs_disc u_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_a      (in_ch.coef_a),
    .in_b      (in_ch.coef_b),
    .in_c      (in_ch.coef_c),
    .out_valid (dc_valid),
    .out_q     (dc_q),
    .out_side  (dc_side)
  );

  qrrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dc_valid),
    .in_q      (dc_q),
    .in_side   (dc_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign s_ext   = (sq_side.kind == qrrs_pkg::KIND_TWO) ? SW'(sq_root) : '0;
  assign num_p   = SW'(sq_side.nb) + s_ext;
  assign num_m   = SW'(sq_side.nb) - s_ext;
  assign den_neg = sq_side.den[qrrs_pkg::DEN_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_valid_r <= 1'b0;
    end else if (en) begin
      n_valid_r <= sq_valid;
    end
    if (en) begin
      nump_r       <= num_p[SW-1] ? NW'(-num_p) : NW'(num_p);
      numm_r       <= num_m[SW-1] ? NW'(-num_m) : NW'(num_m);
      den_r        <= den_neg ? qrrs_pkg::DEN_W'(-sq_side.den) : sq_side.den;
      sidep_r.kind <= sq_side.kind;
      sidep_r.neg  <= num_p[SW-1] != den_neg;
      sidem_r.kind <= sq_side.kind;
      sidem_r.neg  <= num_m[SW-1] != den_neg;
    end
  end

  qrrs_div u_div_plus (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (n_valid_r),
    .in_num    (nump_r),
    .in_den    (den_r),
    .in_side   (sidep_r),
    .out_valid (dp_valid),
    .out_quo   (quo_p),
    .out_side  (dp_side)
  );

  qrrs_div u_div_minus (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (n_valid_r),
    .in_num    (numm_r),
    .in_den    (den_r),
    .in_side   (sidem_r),
    .out_valid (dm_valid),
    .out_quo   (quo_m),
    .out_side  (dm_side)
  );

  // saturate to the signed root range and apply the quotient sign
  function automatic logic [RW-1:0] sat_root(input logic [NW-1:0] mag, input logic neg);
    logic [RW-1:0] res;
    if (neg) begin
      if (mag[NW-1] && (mag[NW-2:0] != '0)) begin
        res = {1'b1, {(RW-1){1'b0}}};
      end else begin
        res = RW'(-mag);
      end
    end else begin
      if (mag[NW-1]) begin
        res = {1'b0, {(RW-1){1'b1}}};
      end else begin
        res = RW'(mag);
      end
    end
    return res;
  endfunction

  always_comb begin
    rp_nxt = '0;
    rm_nxt = '0;
    unique case (dp_side.kind)
      qrrs_pkg::KIND_TWO: begin
        rp_nxt = sat_root(quo_p, dp_side.neg);
        rm_nxt = sat_root(quo_m, dm_side.neg);
      end
      qrrs_pkg::KIND_REPEAT,
      qrrs_pkg::KIND_LINEAR: begin
        rp_nxt = sat_root(quo_p, dp_side.neg);
      end
      default: begin
        rp_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dp_valid && dm_valid;
    end
    if (en) begin
      kind_r <= dp_side.kind;
      rp_r   <= rp_nxt;
      rm_r   <= rm_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.root_kind  = kind_r;
  assign out_ch.root_plus  = rp_r;
  assign out_ch.root_minus = rm_r;

endmodule

@@ src/qrrs_disc.sv @@
`timescale 1ns / 1ps
// Two-stage front end: coefficient magnitudes and products, then discriminant and case decode.
// Depends on qrrs_pkg.
module qrrs_disc (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [qrrs_pkg::COEF_W-1:0]  in_a,
  input  logic signed [qrrs_pkg::COEF_W-1:0]  in_b,
  input  logic signed [qrrs_pkg::COEF_W-1:0]  in_c,
  output logic                                out_valid,
  output logic [qrrs_pkg::DISC_W-1:0]         out_q,
  output qrrs_pkg::sq_side_t                  out_side
);

  localparam int CW = qrrs_pkg::COEF_W;
  localparam int PW = qrrs_pkg::PROD_W;

  logic [CW-1:0]          mag_a, mag_b, mag_c;
  logic                   p_valid_r;
  logic [PW-1:0]          bb_r, ac_r;
  logic signed [CW-1:0]   a_r, b_r, c_r;

  logic [PW+1:0]          ac4, q_sum, q_diff;
  logic                   ac_neg;
  logic signed [qrrs_pkg::NB_W-1:0] b_ext, c_ext;
  logic                   d_valid_r;
  logic [qrrs_pkg::DISC_W-1:0] q_r, q_nxt;
  qrrs_pkg::sq_side_t     side_r, side_nxt;

  assign mag_a = in_a[CW-1] ? CW'(-in_a) : CW'(in_a);
  assign mag_b = in_b[CW-1] ? CW'(-in_b) : CW'(in_b);
  assign mag_c = in_c[CW-1] ? CW'(-in_c) : CW'(in_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= in_valid;
    end
    if (en) begin
      bb_r <= mag_b * mag_b;
      ac_r <= mag_a * mag_c;
      a_r  <= in_a;
      b_r  <= in_b;
      c_r  <= in_c;
    end
  end

  assign ac4    = {ac_r, 2'b00};
  assign q_sum  = (PW+2)'(bb_r) + ac4;
  assign q_diff = (PW+2)'(bb_r) - ac4;
  assign ac_neg = (a_r[CW-1] != c_r[CW-1]) && (c_r != '0);
  assign b_ext  = qrrs_pkg::NB_W'(b_r);
  assign c_ext  = qrrs_pkg::NB_W'(c_r);

  always_comb begin
    side_nxt.kind = qrrs_pkg::KIND_NONE;
    side_nxt.nb   = -(b_ext <<< qrrs_pkg::FRAC_BITS);
    side_nxt.den  = qrrs_pkg::DEN_W'(a_r) <<< 1;
    q_nxt         = '0;
    if (a_r == '0) begin
      side_nxt.nb  = -(c_ext <<< qrrs_pkg::FRAC_BITS);
      side_nxt.den = qrrs_pkg::DEN_W'(b_r);
      if (b_r != '0) begin
        side_nxt.kind = qrrs_pkg::KIND_LINEAR;
      end else if (c_r == '0) begin
        side_nxt.kind = qrrs_pkg::KIND_ALL;
      end else begin
        side_nxt.kind = qrrs_pkg::KIND_NONE;
      end
    end else if (!ac_neg && ((PW+2)'(bb_r) < ac4)) begin
      side_nxt.kind = qrrs_pkg::KIND_NONE;
    end else begin
      q_nxt = ac_neg ? q_sum[qrrs_pkg::DISC_W-1:0] : q_diff[qrrs_pkg::DISC_W-1:0];
      side_nxt.kind = (q_nxt == '0) ? qrrs_pkg::KIND_REPEAT : qrrs_pkg::KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= p_valid_r;
    end
    if (en) begin
      q_r    <= q_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = d_valid_r;
  assign out_q     = q_r;
  assign out_side  = side_r;

endmodule

@@ src/qrrs_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root of q * 2^(2*FRAC_BITS), one root bit per stage.
// Depends on qrrs_pkg.
module qrrs_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [qrrs_pkg::DISC_W-1:0]   in_q,
  input  qrrs_pkg::sq_side_t            in_side,
  output logic                          out_valid,
  output logic [qrrs_pkg::SQRT_W-1:0]   out_root,
  output qrrs_pkg::sq_side_t            out_side
);

  localparam int STEPS = qrrs_pkg::SQRT_W;
  localparam int RW    = qrrs_pkg::SQ_REM_W;
  localparam int QW    = qrrs_pkg::QPAD_W;

  logic [STEPS-1:0]    valid_r, valid_src;
  logic [RW-1:0]       rem_r   [STEPS];
  logic [RW-1:0]       rem_src [STEPS];
  logic [RW-1:0]       rem_nxt [STEPS];
  logic [STEPS-1:0]    root_r   [STEPS];
  logic [STEPS-1:0]    root_src [STEPS];
  logic [STEPS-1:0]    root_nxt [STEPS];
  logic [QW-1:0]       rad_r   [STEPS];
  logic [QW-1:0]       rad_src [STEPS];
  qrrs_pkg::sq_side_t  side_r   [STEPS];
  qrrs_pkg::sq_side_t  side_src [STEPS];

  genvar k;
  generate
    for (k = 0; k < STEPS; k++) begin : g_src
      if (k == 0) begin : g_first
        assign valid_src[k] = in_valid;
        assign rem_src[k]   = '0;
        assign root_src[k]  = '0;
        assign rad_src[k]   = QW'(in_q);
        assign side_src[k]  = in_side;
      end else begin : g_next
        assign valid_src[k] = valid_r[k-1];
        assign rem_src[k]   = rem_r[k-1];
        assign root_src[k]  = root_r[k-1];
        assign rad_src[k]   = rad_r[k-1];
        assign side_src[k]  = side_r[k-1];
      end
    end
  endgenerate

  always_comb begin
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    for (int i = 0; i < STEPS; i++) begin
      rem_sh = {rem_src[i], rad_src[i][QW-1 -: 2]};
      trial  = (RW+2)'({root_src[i], 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt[i]  = RW'(rem_sh - trial);
        root_nxt[i] = {root_src[i][STEPS-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = RW'(rem_sh);
        root_nxt[i] = {root_src[i][STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= valid_src;
    end
    if (en) begin
      for (int i = 0; i < STEPS; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        rad_r[i]  <= rad_src[i] << 2;
        side_r[i] <= side_src[i];
      end
    end
  end

  assign out_valid = valid_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

@@ src/qrrs_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on qrrs_pkg.
module qrrs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [qrrs_pkg::NUM_W-1:0]    in_num,
  input  logic [qrrs_pkg::DEN_W-1:0]    in_den,
  input  qrrs_pkg::div_side_t           in_side,
  output logic                          out_valid,
  output logic [qrrs_pkg::NUM_W-1:0]    out_quo,
  output qrrs_pkg::div_side_t           out_side
);

  localparam int STEPS = qrrs_pkg::NUM_W;
  localparam int DW    = qrrs_pkg::DEN_W;

  logic [STEPS-1:0]     valid_r, valid_src;
  logic [DW-1:0]        rem_r   [STEPS];
  logic [DW-1:0]        rem_src [STEPS];
  logic [DW-1:0]        rem_nxt [STEPS];
  logic [STEPS-1:0]     work_r   [STEPS];
  logic [STEPS-1:0]     work_src [STEPS];
  logic [STEPS-1:0]     work_nxt [STEPS];
  logic [DW-1:0]        den_r   [STEPS];
  logic [DW-1:0]        den_src [STEPS];
  qrrs_pkg::div_side_t  side_r   [STEPS];
  qrrs_pkg::div_side_t  side_src [STEPS];

  genvar k;
  generate
    for (k = 0; k < STEPS; k++) begin : g_src
      if (k == 0) begin : g_first
        assign valid_src[k] = in_valid;
        assign rem_src[k]   = '0;
        assign work_src[k]  = in_num;
        assign den_src[k]   = in_den;
        assign side_src[k]  = in_side;
      end else begin : g_next
        assign valid_src[k] = valid_r[k-1];
        assign rem_src[k]   = rem_r[k-1];
        assign work_src[k]  = work_r[k-1];
        assign den_src[k]   = den_r[k-1];
        assign side_src[k]  = side_r[k-1];
      end
    end
  endgenerate

  // numerator bits leave the top of the work word, quotient bits enter at the bottom
  always_comb begin
    logic [DW:0] rem_sh;
    logic        ge;
    for (int i = 0; i < STEPS; i++) begin
      rem_sh      = {rem_src[i], work_src[i][STEPS-1]};
      ge          = rem_sh >= {1'b0, den_src[i]};
      rem_nxt[i]  = ge ? DW'(rem_sh - {1'b0, den_src[i]}) : DW'(rem_sh);
      work_nxt[i] = {work_src[i][STEPS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= valid_src;
    end
    if (en) begin
      for (int i = 0; i < STEPS; i++) begin
        rem_r[i]  <= rem_nxt[i];
        work_r[i] <= work_nxt[i];
        den_r[i]  <= den_src[i];
        side_r[i] <= side_src[i];
      end
    end
  end

  assign out_valid = valid_r[STEPS-1];
  assign out_quo   = work_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule
